@@ rtl/pfhv_pkg.sv @@
// Shared types and constants for the packed file header validator.
package pfhv_pkg;

    typedef enum logic [2:0] {
        REJ_OK     = 3'd0,
        REJ_SHORT  = 3'd1,
        REJ_MAGIC  = 3'd2,
        REJ_LENGTH = 3'd3,
        REJ_NAME   = 3'd4,
        REJ_EMPTY  = 3'd5
    } reject_t;

    localparam int unsigned NAME_AT     = 8;
    localparam int unsigned SIZE_AT     = 4;
    localparam int unsigned PARAM_BYTES = 10;
    localparam int unsigned POS_W       = 6;

    localparam logic [31:0] RAW_CEILING = 32'h1000_0000;
    localparam logic [7:0]  PRINT_LO    = 8'h20;
    localparam logic [7:0]  PRINT_HI    = 8'h7e;

    localparam logic [7:0] MAGIC_SIG [4] = '{8'h58, 8'h50, 8'h41, 8'h4b};

    // Gathered header, handed from the parser to the evaluator
    typedef struct packed {
        logic        magic_bad;
        logic        name_bad;
        logic [31:0] declared;
        logic [31:0] raw;
        logic [3:0]  name_len;
        logic [63:0] params_low;
        logic [15:0] params_high;
    } hdr_rec_t;

endpackage

@@ rtl/packed_file_header_validator_top.sv @@
// Top level of the packed file header validator: parser, record queue, evaluator.
//
// Input channel (s_*): one header byte per beat, offsets 0 to HDR-1 in order,
// where HDR = NAME_BYTES + 22 (35 with the default 13-byte name).
// Result channel (m_*): one beat per complete header, carrying the reject
// code, truncation flag, stream size, raw size, name length and parameters.
// Configuration: cfg_we writes cfg_wdata into the file length register on the
// same edge; write it only between headers.
// Throughput: one byte per cycle, sustained; the parser never holds a byte
// back unless the two-entry record queue is full.
// The record enters the queue on the edge that takes the last header
// byte; the classification stage and then the size stage with output register
// follow it, and m_valid rises once the record has passed through both.
// While m_ready is low the output register, the classification stage and the
// two queue entries hold up to four finished headers; then s_ready drops, even
// mid-header, until the receiver takes a beat.
// Reset (aresetn low at a clock edge) rearms the byte counter, empties the
// queue and pipeline, and clears the file length to zero.
module packed_file_header_validator_top
    import pfhv_pkg::*;
#(
    parameter int unsigned NAME_BYTES = 13
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_header_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_reject_code,
    output logic        m_truncated,
    output logic [31:0] m_stream_size,
    output logic [31:0] m_raw_size,
    output logic [3:0]  m_name_length,
    output logic [63:0] m_params_low,
    output logic [15:0] m_params_high
);

    // file length register, already saturated upstream
    logic [31:0] file_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else if (cfg_we) begin
            file_length_reg <= cfg_wdata;
        end
    end

    // parser -> queue
    logic     fr_valid, fr_ready;
    hdr_rec_t fr_rec;
    // queue -> evaluator
    logic     qb_valid, qb_ready;
    hdr_rec_t qb_rec;

    pfhv_front #(
        .NAME_BYTES (NAME_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_valid),
        .byte_data  (s_header_byte),
        .byte_ready (s_ready),
        .rec_valid  (fr_valid),
        .rec        (fr_rec),
        .rec_ready  (fr_ready)
    );

    // decouples the byte stream from result back-pressure
    pfhv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_data  (fr_rec),
        .wr_ready (fr_ready),
        .rd_valid (qb_valid),
        .rd_data  (qb_rec),
        .rd_ready (qb_ready)
    );

    pfhv_back #(
        .NAME_BYTES (NAME_BYTES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .file_length     (file_length_reg),
        .rec_valid       (qb_valid),
        .rec             (qb_rec),
        .rec_ready       (qb_ready),
        .res_valid       (m_valid),
        .res_ready       (m_ready),
        .res_code        (m_reject_code),
        .res_truncated   (m_truncated),
        .res_stream_size (m_stream_size),
        .res_raw_size    (m_raw_size),
        .res_name_length (m_name_length),
        .res_params_low  (m_params_low),
        .res_params_high (m_params_high)
    );

endmodule

@@ rtl/pfhv_front.sv @@
// Byte parser: walks the header one beat at a time and emits one gathered record.
module pfhv_front
    import pfhv_pkg::*;
#(
    parameter int unsigned NAME_BYTES = 13
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    output logic              byte_ready,
    output logic              rec_valid,
    output hdr_rec_t          rec,
    input  logic              rec_ready
);

    localparam int unsigned RAW_AT   = NAME_AT + NAME_BYTES;
    localparam int unsigned PARAM_AT = RAW_AT + 4;
    localparam int unsigned HDR      = PARAM_AT + PARAM_BYTES;
    localparam int unsigned NCW      = $clog2(NAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_bad_reg, magic_bad_next;
    logic             name_bad_reg, name_bad_next;
    logic [31:0]      declared_reg, declared_next;
    logic [31:0]      raw_reg, raw_next;
    logic             padding_reg, padding_next;
    logic [NCW-1:0]   count_reg, count_next;
    logic [63:0]      plow_reg, plow_next;
    logic [15:0]      phigh_reg, phigh_next;

    logic             take;
    logic             last;
    logic [POS_W-1:0] size_off, raw_off, param_off;
    logic [4:0]       count_ext;

    assign byte_ready = rec_ready;
    assign take       = byte_valid && byte_ready;
    assign last       = (pos_reg == POS_W'(HDR - 1));
    assign size_off   = pos_reg - POS_W'(SIZE_AT);
    assign raw_off    = pos_reg - POS_W'(RAW_AT);
    assign param_off  = pos_reg - POS_W'(PARAM_AT);

    always_comb begin
        magic_bad_next = magic_bad_reg;
        name_bad_next  = name_bad_reg;
        declared_next  = declared_reg;
        raw_next       = raw_reg;
        padding_next   = padding_reg;
        count_next     = count_reg;
        plow_next      = plow_reg;
        phigh_next     = phigh_reg;

        if (pos_reg < POS_W'(SIZE_AT)) begin
            if (byte_data != MAGIC_SIG[pos_reg[1:0]]) begin
                magic_bad_next = 1'b1;
            end
        end else if (pos_reg < POS_W'(NAME_AT)) begin
            declared_next[8*size_off[1:0] +: 8] = byte_data;
        end else if (pos_reg < POS_W'(RAW_AT)) begin
            if (!padding_reg) begin
                if (byte_data == 8'h00) begin
                    padding_next = 1'b1;
                end else if (byte_data >= PRINT_LO && byte_data <= PRINT_HI) begin
                    count_next = count_reg + NCW'(1);
                end else begin
                    name_bad_next = 1'b1;
                end
            end else if (byte_data != 8'h00) begin
                name_bad_next = 1'b1;
            end
            // empty name caught on the last name byte
            if (pos_reg == POS_W'(RAW_AT - 1) && count_next == '0) begin
                name_bad_next = 1'b1;
            end
        end else if (pos_reg < POS_W'(PARAM_AT)) begin
            raw_next[8*raw_off[1:0] +: 8] = byte_data;
        end else begin
            if (!param_off[3]) begin
                plow_next[8*param_off[2:0] +: 8] = byte_data;
            end else begin
                phigh_next[8*param_off[0] +: 8] = byte_data;
            end
        end

        pos_next = pos_reg + POS_W'(1);
    end

    assign count_ext       = 5'(count_next);
    assign rec_valid       = take && last;
    assign rec.magic_bad   = magic_bad_next;
    assign rec.name_bad    = name_bad_next;
    assign rec.declared    = declared_next;
    assign rec.raw         = raw_next;
    assign rec.name_len    = count_ext[3:0];
    assign rec.params_low  = plow_next;
    assign rec.params_high = phigh_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && last)) begin
            pos_reg       <= '0;
            magic_bad_reg <= 1'b0;
            name_bad_reg  <= 1'b0;
            declared_reg  <= '0;
            raw_reg       <= '0;
            padding_reg   <= 1'b0;
            count_reg     <= '0;
            plow_reg      <= '0;
            phigh_reg     <= '0;
        end else if (take) begin
            pos_reg       <= pos_next;
            magic_bad_reg <= magic_bad_next;
            name_bad_reg  <= name_bad_next;
            declared_reg  <= declared_next;
            raw_reg       <= raw_next;
            padding_reg   <= padding_next;
            count_reg     <= count_next;
            plow_reg      <= plow_next;
            phigh_reg     <= phigh_next;
        end
    end

endmodule

@@ rtl/pfhv_queue.sv @@
// Two-entry record queue between parser and evaluator.
module pfhv_queue
    import pfhv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    input  hdr_rec_t wr_data,
    output logic     wr_ready,
    output logic     rd_valid,
    output hdr_rec_t rd_data,
    input  logic     rd_ready
);

    hdr_rec_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ rtl/pfhv_back.sv @@
// Evaluator: two-stage reject classification and size arithmetic, registered result.
module pfhv_back
    import pfhv_pkg::*;
#(
    parameter int unsigned NAME_BYTES = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] file_length,
    input  logic        rec_valid,
    input  hdr_rec_t    rec,
    output logic        rec_ready,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  res_code,
    output logic        res_truncated,
    output logic [31:0] res_stream_size,
    output logic [31:0] res_raw_size,
    output logic [3:0]  res_name_length,
    output logic [63:0] res_params_low,
    output logic [15:0] res_params_high
);

    localparam int unsigned HDR      = NAME_AT + NAME_BYTES + 4 + PARAM_BYTES;
    localparam logic [31:0] HDR_W    = 32'(HDR);
    localparam logic [31:0] MIN_FILE = 32'(HDR + 1);

    // stage A
    logic        a_valid_reg;
    reject_t     a_code_reg, a_code_next;
    logic        a_trunc_reg, a_trunc_next;
    logic [31:0] a_limit_reg, a_limit_next;
    logic [31:0] a_raw_reg;
    logic [3:0]  a_nlen_reg;
    logic [63:0] a_plow_reg;
    logic [15:0] a_phigh_reg;
    logic        a_ready;

    // stage B / result
    logic        b_valid_reg;
    reject_t     b_code_next;
    logic [2:0]  b_code_reg;
    logic        b_trunc_reg;
    logic [31:0] b_stream_reg, b_stream_next;
    logic [31:0] b_raw_reg;
    logic [3:0]  b_nlen_reg;
    logic [63:0] b_plow_reg;
    logic [15:0] b_phigh_reg;
    logic        b_ready;
    logic        b_ok;

    assign b_ready   = !b_valid_reg || res_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign rec_ready = a_ready;

    always_comb begin
        a_trunc_next = (rec.declared > file_length);
        a_limit_next = a_trunc_next ? file_length : rec.declared;
        if (file_length < MIN_FILE) begin
            a_code_next = REJ_SHORT;
        end else if (rec.magic_bad) begin
            a_code_next = REJ_MAGIC;
        end else if (rec.declared < MIN_FILE || rec.raw == '0 || rec.raw > RAW_CEILING) begin
            a_code_next = REJ_LENGTH;
        end else if (rec.name_bad) begin
            a_code_next = REJ_NAME;
        end else begin
            a_code_next = REJ_OK;
        end
    end

    always_comb begin
        b_code_next   = a_code_reg;
        b_stream_next = a_limit_reg - HDR_W;
        if (a_code_reg == REJ_OK && a_limit_reg <= HDR_W) begin
            b_code_next = REJ_EMPTY;
        end
    end
    assign b_ok = (b_code_next == REJ_OK);

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_code_reg  <= a_code_next;
            a_trunc_reg <= a_trunc_next;
            a_limit_reg <= a_limit_next;
            a_raw_reg   <= rec.raw;
            a_nlen_reg  <= rec.name_len;
            a_plow_reg  <= rec.params_low;
            a_phigh_reg <= rec.params_high;
        end
        if (b_ready) begin
            b_code_reg   <= b_code_next;
            // rejected headers report zero in every other field
            b_trunc_reg  <= b_ok && a_trunc_reg;
            b_stream_reg <= b_ok ? b_stream_next : '0;
            b_raw_reg    <= b_ok ? a_raw_reg : '0;
            b_nlen_reg   <= b_ok ? a_nlen_reg : '0;
            b_plow_reg   <= b_ok ? a_plow_reg : '0;
            b_phigh_reg  <= b_ok ? a_phigh_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= rec_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    assign res_valid       = b_valid_reg;
    assign res_code        = b_code_reg;
    assign res_truncated   = b_trunc_reg;
    assign res_stream_size = b_stream_reg;
    assign res_raw_size    = b_raw_reg;
    assign res_name_length = b_nlen_reg;
    assign res_params_low  = b_plow_reg;
    assign res_params_high = b_phigh_reg;

endmodule
